@@ hdl/egas_pkg.sv @@
// Shared types, constants and small modulo helpers for the epsilon-greedy arm selector.
package egas_pkg;

  // Field widths fixed by the beat format.
  localparam int unsigned CNT_W     = 24;
  localparam int unsigned ROLL_W    = 15;
  localparam int unsigned PCT_W     = 7;
  localparam int unsigned ARM_W     = 3;
  localparam int unsigned TIE_W     = 4;
  localparam int unsigned MAX_ARMS  = 8;
  localparam int unsigned NUM_LANES = MAX_ARMS / 2;

  // Reset value of the explore percentage.
  localparam logic [PCT_W-1:0] PCT_RESET = 7'd10;

  // Roll modulo 100 by reciprocal multiply: floor(x * 5243 / 2^19) is exact for x < 43699.
  localparam int unsigned ROLL_MOD      = 100;
  localparam int unsigned EXPLORE_RECIP = 5243;
  localparam int unsigned EXPLORE_SHIFT = 19;
  localparam int unsigned RECIP_W       = 13;
  localparam int unsigned PROD_W        = ROLL_W + RECIP_W;
  localparam int unsigned QUOT_W        = PROD_W - EXPLORE_SHIFT;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ROLL_W-1:0] roll_t;

  // Remainder by 3: 4 is 1 modulo 3, so the 2-bit digits are summed and folded.
  function automatic logic [1:0] mod3(input roll_t x);
    logic [15:0] xp;
    logic [4:0]  s;
    logic [2:0]  t;
    xp = {1'b0, x};
    s = 5'(xp[1:0]) + 5'(xp[3:2]) + 5'(xp[5:4]) + 5'(xp[7:6])
      + 5'(xp[9:8]) + 5'(xp[11:10]) + 5'(xp[13:12]) + 5'(xp[15:14]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // Remainder by 5: 16 is 1 modulo 5, so the 4-bit digits are summed and folded.
  function automatic logic [2:0] mod5(input roll_t x);
    logic [5:0] s;
    logic [4:0] t;
    s = 6'(x[3:0]) + 6'(x[7:4]) + 6'(x[11:8]) + 6'(x[14:12]);
    t = 5'(s[3:0]) + 5'(s[5:4]);
    if (t >= 5'd15) begin
      t = t - 5'd15;
    end else if (t >= 5'd10) begin
      t = t - 5'd10;
    end else if (t >= 5'd5) begin
      t = t - 5'd5;
    end
    return t[2:0];
  endfunction

  // Remainder by 7: 8 is 1 modulo 7, so the 3-bit digits are summed and folded.
  function automatic logic [2:0] mod7(input roll_t x);
    logic [5:0] s;
    logic [3:0] t;
    s = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    t = 4'(s[2:0]) + 4'(s[5:3]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  // Remainder of a roll by a divisor from 1 to 8.
  function automatic logic [ARM_W-1:0] mod_small(input roll_t x, input logic [TIE_W-1:0] d);
    logic [1:0] r3;
    logic [ARM_W-1:0] r;
    r3 = mod3(x);
    case (d)
      4'd1: r = '0;
      4'd2: r = {2'b00, x[0]};
      4'd3: r = {1'b0, r3};
      4'd4: r = {1'b0, x[1:0]};
      4'd5: r = mod5(x);
      // The remainder by 6 joins the remainders by 2 and 3.
      4'd6: begin
        if (r3[0] == x[0]) begin
          r = {1'b0, r3};
        end else begin
          r = 3'({1'b0, r3} + 3'd3);
        end
      end
      4'd7: r = mod7(x);
      4'd8: r = x[2:0];
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/egas_lane.sv @@
// One compare lane: registers a pair of arm counts and the larger of the two.
module egas_lane
  import egas_pkg::*;
(
  input  logic clk,
  input  logic en,
  input  cnt_t cnt_a,
  input  cnt_t cnt_b,
  output cnt_t cnt_a_r,
  output cnt_t cnt_b_r,
  output cnt_t pair_max_r
);

  // Pair compare, loaded whenever the first stage advances.
  always_ff @(posedge clk) begin
    if (en) begin
      cnt_a_r    <= cnt_a;
      cnt_b_r    <= cnt_b;
      pair_max_r <= (cnt_b > cnt_a) ? cnt_b : cnt_a;
    end
  end

endmodule

@@ hdl/egas_merge.sv @@
// Merging stage: reduces the lane maxima to the overall maximum count.
module egas_merge
  import egas_pkg::*;
(
  input  logic                      clk,
  input  logic                      en,
  input  cnt_t [NUM_LANES-1:0]      pair_max,
  input  cnt_t [MAX_ARMS-1:0]       cnt,
  output cnt_t                      max_r,
  output cnt_t [MAX_ARMS-1:0]       cnt_r
);

  cnt_t max_nxt;

  // Running maximum over the few lane results.
  always_comb begin
    max_nxt = pair_max[0];
    for (int l = 1; l < NUM_LANES; l++) begin
      if (pair_max[l] > max_nxt) begin
        max_nxt = pair_max[l];
      end
    end
  end

  // The counts travel along so that the next stage can test them for ties.
  always_ff @(posedge clk) begin
    if (en) begin
      max_r <= max_nxt;
      cnt_r <= cnt;
    end
  end

endmodule

@@ hdl/epsilon_greedy_arm_select.sv @@
// Top level of the epsilon-greedy arm selector: lanes, merge, tie pick and explore path.
//
// Usage: one input beat carries the eight arm counts and three random words;
// one output beat returns the chosen arm, the explore flag and the number of
// arms tied at the maximum count. Both channels use valid and stall; a beat
// moves on a rising edge with valid high and stall low.
// The explore percentage is written through cfg_wr_en/cfg_wr_data while the
// block is idle; it takes effect for the next beat.
// An input beat passes through three register stages, and one beat is taken
// every cycle while in_stall is low. The stages are the pair-compare lanes with
// the explore quotient multiply, the lane merge with the remainder compare, and
// the tie count and k-th tied arm pick that loads the output register.
// Reset clears all stage valids and sets the explore percentage to 10.
// While the receiver stalls, the output beat holds; empty stages behind it
// still fill, and in_stall rises only once every stage holds a beat.
module epsilon_greedy_arm_select
  import egas_pkg::*;
#(
  parameter int ARM_COUNT = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [PCT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  cnt_t              in_arm_count_0,
  input  cnt_t              in_arm_count_1,
  input  cnt_t              in_arm_count_2,
  input  cnt_t              in_arm_count_3,
  input  cnt_t              in_arm_count_4,
  input  cnt_t              in_arm_count_5,
  input  cnt_t              in_arm_count_6,
  input  cnt_t              in_arm_count_7,
  input  roll_t             in_explore_roll,
  input  roll_t             in_explore_arm_roll,
  input  roll_t             in_tie_roll,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ARM_W-1:0]  out_chosen_arm,
  output logic              out_explored,
  output logic [TIE_W-1:0]  out_tie_count
);

  // Arms beyond the count fields or below one saturate.
  localparam int ACTIVE = (ARM_COUNT < 1) ? 1 :
                          ((ARM_COUNT > int'(MAX_ARMS)) ? int'(MAX_ARMS) : ARM_COUNT);

  logic [PCT_W-1:0] pct_r;
  logic             v1_r, v2_r, v3_r;
  logic             en1, en2, en3;

  cnt_t [MAX_ARMS-1:0]  cnt_all;
  cnt_t [MAX_ARMS-1:0]  cnt_in;
  cnt_t [MAX_ARMS-1:0]  s1_cnt;
  cnt_t [NUM_LANES-1:0] s1_pmax;
  cnt_t [MAX_ARMS-1:0]  s2_cnt;
  cnt_t                 s2_max;

  logic [PROD_W-1:0]              prod;
  logic [QUOT_W-1:0]              q_nxt;
  logic [MAX_ARMS-1:0][ARM_W-1:0] tmod_nxt;
  logic [ARM_W-1:0]               amod_nxt;

  roll_t                          s1_roll_r;
  logic [QUOT_W-1:0]              s1_q_r;
  logic [MAX_ARMS-1:0][ARM_W-1:0] s1_tmod_r;
  logic [ARM_W-1:0]               s1_amod_r;

  roll_t                          rem_full;
  logic                           explore_nxt;
  logic                           s2_explore_r;
  logic [MAX_ARMS-1:0][ARM_W-1:0] s2_tmod_r;
  logic [ARM_W-1:0]               s2_amod_r;

  logic [MAX_ARMS-1:0] tie_mask;
  logic [TIE_W-1:0]    ties;
  logic [ARM_W-1:0]    rank;
  logic [ARM_W-1:0]    seen;
  logic [ARM_W-1:0]    greedy_arm;
  logic                found;

  logic [ARM_W-1:0] out_chosen_arm_r;
  logic             out_explored_r;
  logic [TIE_W-1:0] out_tie_count_r;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pct_r <= PCT_RESET;
    end else if (cfg_wr_en) begin
      pct_r <= cfg_wr_data;
    end
  end

  // Each stage advances when it is empty or the stage after it advances.
  assign en3      = !v3_r || !out_stall;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  // Inactive arms enter the lanes as zero counts and never join a tie.
  assign cnt_all = {in_arm_count_7, in_arm_count_6, in_arm_count_5, in_arm_count_4,
                    in_arm_count_3, in_arm_count_2, in_arm_count_1, in_arm_count_0};

  always_comb begin
    for (int i = 0; i < int'(MAX_ARMS); i++) begin
      cnt_in[i] = (i < ACTIVE) ? cnt_all[i] : '0;
    end
  end

  // Compare lanes, one per pair of arms.
  for (genvar l = 0; l < int'(NUM_LANES); l++) begin : g_lane
    egas_lane u_lane (
      .clk        (clk),
      .en         (en1),
      .cnt_a      (cnt_in[2*l]),
      .cnt_b      (cnt_in[2*l+1]),
      .cnt_a_r    (s1_cnt[2*l]),
      .cnt_b_r    (s1_cnt[2*l+1]),
      .pair_max_r (s1_pmax[l])
    );
  end

  // Merge of the lane maxima.
  egas_merge u_merge (
    .clk      (clk),
    .en       (en2),
    .pair_max (s1_pmax),
    .cnt      (s1_cnt),
    .max_r    (s2_max),
    .cnt_r    (s2_cnt)
  );

  // First stage of the random path: quotient of the explore roll by 100, the tie
  // roll modulo every possible tie count and the explore arm roll modulo the arm count.
  assign prod     = PROD_W'(in_explore_roll) * PROD_W'(EXPLORE_RECIP);
  assign q_nxt    = QUOT_W'(prod >> EXPLORE_SHIFT);
  assign amod_nxt = mod_small(in_explore_arm_roll, TIE_W'(ACTIVE));

  always_comb begin
    for (int d = 0; d < int'(MAX_ARMS); d++) begin
      tmod_nxt[d] = mod_small(in_tie_roll, TIE_W'(d + 1));
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_roll_r <= in_explore_roll;
      s1_q_r    <= q_nxt;
      s1_tmod_r <= tmod_nxt;
      s1_amod_r <= amod_nxt;
    end
  end

  // Second stage: remainder by 100 against the explore percentage.
  assign rem_full    = s1_roll_r - ROLL_W'(s1_q_r) * ROLL_W'(ROLL_MOD);
  assign explore_nxt = rem_full < ROLL_W'(pct_r);

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_explore_r <= explore_nxt;
      s2_tmod_r    <= s1_tmod_r;
      s2_amod_r    <= s1_amod_r;
    end
  end

  // Third stage: tie mask, tie count and the tied arm at the rolled rank.
  always_comb begin
    ties = '0;
    for (int i = 0; i < int'(MAX_ARMS); i++) begin
      tie_mask[i] = (i < ACTIVE) && (s2_cnt[i] == s2_max);
      ties        = ties + TIE_W'(tie_mask[i]);
    end
    rank       = s2_tmod_r[ARM_W'(ties - TIE_W'(1))];
    seen       = '0;
    found      = 1'b0;
    greedy_arm = '0;
    for (int i = 0; i < int'(MAX_ARMS); i++) begin
      if (tie_mask[i] && !found) begin
        if (seen == rank) begin
          greedy_arm = ARM_W'(i);
          found      = 1'b1;
        end
        seen = seen + ARM_W'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en3) begin
      out_chosen_arm_r <= s2_explore_r ? s2_amod_r : greedy_arm;
      out_explored_r   <= s2_explore_r;
      out_tie_count_r  <= ties;
    end
  end

  assign out_valid      = v3_r;
  assign out_chosen_arm = out_chosen_arm_r;
  assign out_explored   = out_explored_r;
  assign out_tie_count  = out_tie_count_r;

`ifndef SYNTHESIS
  // A delivered beat always reports between one and all active arms tied.
  a_tie_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_tie_count != '0) && (int'(out_tie_count) <= ACTIVE))
    else $error("tie count out of range");

  // Every chosen arm is one of the active arms.
  a_arm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_chosen_arm) < ACTIVE))
    else $error("chosen arm beyond active arms");

  // The input side stalls only when every stage holds a beat behind a stalled output.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid && out_stall))
    else $error("input stalled with room in the pipeline");
`endif

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for the epsilon-greedy arm selector.
module tb_top;
  import egas_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 4;
  localparam int DUT_ARMS     = 8;
  localparam int ACTIVE_ARMS  = (DUT_ARMS < 1) ? 1 :
                                ((DUT_ARMS > MAX_ARMS) ? MAX_ARMS : DUT_ARMS);
  localparam int PERCENT_SPAN = 100;
  localparam int DIR_ROWS     = 20;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_BEATS  = 100;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 2_000_000;

  localparam cnt_t CNT_MAX  = 24'hFFFFFF;
  localparam cnt_t CNT_HALF = 24'h800000;
  localparam cnt_t CNT_LOW  = 24'h7FFFFF;
  localparam cnt_t CNT_A    = 24'hAAAAAA;
  localparam cnt_t CNT_5    = 24'h555555;

  // One input beat: the arm counts and the three random words.
  typedef struct {
    cnt_t  cnt [MAX_ARMS];
    roll_t explore_roll;
    roll_t arm_roll;
    roll_t tie_roll;
  } arm_beat_t;

  // One output beat.
  typedef struct {
    logic [ARM_W-1:0] arm;
    logic             explored;
    logic [TIE_W-1:0] ties;
  } arm_pick_t;

  // Directed row: explore setting, beat, and the pick when it is obvious.
  typedef struct {
    logic [PCT_W-1:0] pct;
    arm_beat_t        beat;
    bit               known;
    arm_pick_t        pick;
  } vote_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [PCT_W-1:0] cfg_wr_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  cnt_t             in_arm_count_0 = '0;
  cnt_t             in_arm_count_1 = '0;
  cnt_t             in_arm_count_2 = '0;
  cnt_t             in_arm_count_3 = '0;
  cnt_t             in_arm_count_4 = '0;
  cnt_t             in_arm_count_5 = '0;
  cnt_t             in_arm_count_6 = '0;
  cnt_t             in_arm_count_7 = '0;
  roll_t            in_explore_roll = '0;
  roll_t            in_explore_arm_roll = '0;
  roll_t            in_tie_roll = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [ARM_W-1:0] out_chosen_arm;
  logic             out_explored;
  logic [TIE_W-1:0] out_tie_count;

  // Model of the explore register and the picks still to come out.
  logic [PCT_W-1:0] explore_pct_model = PCT_RESET;
  arm_pick_t        pending_picks [$];
  arm_pick_t        due_pick;
  arm_pick_t        no_pick = '{3'd0, 1'b0, 4'd0};
  bit               quiet_phase = 1'b0;
  int               errors = 0;
  int               picks_checked = 0;
  int               explored_seen = 0;
  int               settings_used = 0;

  // Obvious picks are typed in; rows marked unknown go through the predictor.
  vote_row_t dir_tab [DIR_ROWS] = '{
    // All counts zero, roll exactly at the threshold: greedy, eight-way tie.
    '{7'd10, '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd10, 15'd0, 15'd0}, 1'b1, '{3'd0, 1'b0, 4'd8}},
    // One below the threshold explores; the tie count is still reported.
    '{7'd10, '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd9, 15'd7, 15'd0}, 1'b1, '{3'd7, 1'b1, 4'd8}},
    // All counts at maximum, explore and tie rolls at maximum, arm roll zero.
    '{7'd10, '{'{CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX},
      15'd32767, 15'd0, 15'd32767}, 1'b1, '{3'd7, 1'b0, 4'd8}},
    '{7'd10, '{'{24'd0, 24'd0, 24'd0, CNT_MAX, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd99, 15'd0, 15'd0}, 1'b1, '{3'd3, 1'b0, 4'd1}},
    '{7'd10, '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, CNT_MAX},
      15'd0, 15'd32767, 15'd0}, 1'b1, '{3'd7, 1'b1, 4'd1}},
    // Three-way tie, third tied arm chosen.
    '{7'd10, '{'{24'd1, CNT_HALF, 24'd2, 24'd3, CNT_HALF, 24'd5, CNT_HALF, 24'd4},
      15'd50, 15'd0, 15'd5}, 1'b1, '{3'd6, 1'b0, 4'd3}},
    // Tie between the outermost arms; roll wraps past 100 to the threshold.
    '{7'd10, '{'{CNT_MAX, CNT_LOW, CNT_LOW, CNT_LOW, CNT_LOW, CNT_LOW, CNT_LOW, CNT_MAX},
      15'd110, 15'd0, 15'd1}, 1'b1, '{3'd7, 1'b0, 4'd2}},
    '{7'd10, '{'{CNT_A, CNT_5, CNT_A, CNT_5, CNT_A, CNT_5, CNT_A, CNT_5},
      15'd109, 15'd3, 15'h2AAA}, 1'b1, '{3'd3, 1'b1, 4'd4}},
    '{7'd10, '{'{CNT_5, CNT_A, CNT_5, CNT_A, CNT_5, CNT_A, CNT_5, CNT_A},
      15'h5555, 15'h5555, 15'h2AAA}, 1'b1, '{3'd5, 1'b0, 4'd4}},
    // Five, six and seven way ties.
    '{7'd10, '{'{24'd7, 24'd7, 24'd0, 24'd7, 24'd7, 24'd1, 24'd7, 24'd2},
      15'h2AAA, 15'h5555, 15'h5555}, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{7'd10, '{'{24'd9, 24'd9, 24'd9, 24'd1, 24'd9, 24'd9, 24'd0, 24'd9},
      15'd1234, 15'd0, 15'd12345}, 1'b0, '{3'd0, 1'b0, 4'd0}},
    '{7'd10, '{'{24'd4, 24'd4, 24'd4, 24'd4, 24'd4, 24'd4, 24'd4, 24'd3},
      15'd77, 15'd0, 15'd32766}, 1'b0, '{3'd0, 1'b0, 4'd0}},
    // Explore percent zero never explores.
    '{7'd0, '{'{CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX},
      15'd0, 15'd0, 15'd3}, 1'b1, '{3'd3, 1'b0, 4'd8}},
    '{7'd0, '{'{24'd0, CNT_MAX, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd32700, 15'd0, 15'd0}, 1'b1, '{3'd1, 1'b0, 4'd1}},
    '{7'd100, '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd99, 15'd5, 15'd0}, 1'b1, '{3'd5, 1'b1, 4'd8}},
    // Explore percent above 100 always explores.
    '{7'd127, '{'{CNT_MAX, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd32767, 15'd32766, 15'd0}, 1'b1, '{3'd6, 1'b1, 4'd1}},
    '{7'd127, '{'{CNT_5, CNT_A, CNT_5, CNT_A, CNT_5, CNT_A, CNT_5, CNT_A},
      15'h5555, 15'h2AAA, 15'd0}, 1'b1, '{3'd2, 1'b1, 4'd4}},
    '{7'd1, '{'{24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0},
      15'd100, 15'd1, 15'd0}, 1'b1, '{3'd1, 1'b1, 4'd8}},
    '{7'd99, '{'{24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8},
      15'd99, 15'd0, 15'd0}, 1'b1, '{3'd7, 1'b0, 4'd1}},
    '{7'd99, '{'{24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8},
      15'd98, 15'd4, 15'd0}, 1'b1, '{3'd4, 1'b1, 4'd1}}
  };

  epsilon_greedy_arm_select #(
    .ARM_COUNT(DUT_ARMS)
  ) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_arm_count_0     (in_arm_count_0),
    .in_arm_count_1     (in_arm_count_1),
    .in_arm_count_2     (in_arm_count_2),
    .in_arm_count_3     (in_arm_count_3),
    .in_arm_count_4     (in_arm_count_4),
    .in_arm_count_5     (in_arm_count_5),
    .in_arm_count_6     (in_arm_count_6),
    .in_arm_count_7     (in_arm_count_7),
    .in_explore_roll    (in_explore_roll),
    .in_explore_arm_roll(in_explore_arm_roll),
    .in_tie_roll        (in_tie_roll),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_chosen_arm     (out_chosen_arm),
    .out_explored       (out_explored),
    .out_tie_count      (out_tie_count)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predict the pick for one beat under the given explore percentage.
  function automatic arm_pick_t predict_pick(input arm_beat_t b, input logic [PCT_W-1:0] pct);
    arm_pick_t   r;
    cnt_t        top;
    int unsigned n_tied;
    int unsigned nth;
    int unsigned seen;
    r = no_pick;
    top = '0;
    n_tied = 0;
    seen = 0;
    for (int i = 0; i < ACTIVE_ARMS; i++) begin
      if (b.cnt[i] > top) top = b.cnt[i];
    end
    for (int i = 0; i < ACTIVE_ARMS; i++) begin
      if (b.cnt[i] == top) n_tied++;
    end
    r.ties = TIE_W'(n_tied);
    if ((int'(b.explore_roll) % PERCENT_SPAN) < int'(pct)) begin
      r.explored = 1'b1;
      r.arm = ARM_W'(int'(b.arm_roll) % ACTIVE_ARMS);
    end else begin
      nth = (int'(b.tie_roll) % n_tied) + 1;
      for (int i = 0; i < ACTIVE_ARMS; i++) begin
        if (b.cnt[i] == top && seen < nth) begin
          seen++;
          if (seen == nth) r.arm = ARM_W'(i);
        end
      end
    end
    return r;
  endfunction

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int idle_len();
    int roll;
    if (quiet_phase) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Random beat, shaped so that ties of every size show up often.
  function automatic arm_beat_t random_beat();
    arm_beat_t b;
    cnt_t      top;
    int        n_top;
    int        order [MAX_ARMS];
    int        j;
    int        tmp;
    int        mode;
    mode = $urandom_range(0, 9);
    top = ($urandom_range(0, 7) == 0) ? CNT_MAX : cnt_t'($urandom);
    n_top = $urandom_range(1, MAX_ARMS);
    for (int i = 0; i < MAX_ARMS; i++) order[i] = i;
    for (int i = MAX_ARMS - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    for (int i = 0; i < MAX_ARMS; i++) begin
      if (mode < 2) begin
        b.cnt[i] = cnt_t'($urandom);
      end else if (mode < 4) begin
        b.cnt[i] = cnt_t'($urandom_range(0, 3));
      end else if (mode < 9) begin
        if (i < n_top || top == 0) begin
          b.cnt[order[i]] = top;
        end else begin
          b.cnt[order[i]] = cnt_t'($urandom_range(0, int'(top) - 1));
        end
      end else begin
        b.cnt[i] = top;
      end
    end
    b.explore_roll = roll_t'($urandom);
    b.arm_roll = roll_t'($urandom);
    b.tie_roll = roll_t'($urandom);
    return b;
  endfunction

  // Send one beat after a random gap and record what should come back.
  task automatic send_beat(input arm_beat_t b, input bit known, input arm_pick_t pick);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_arm_count_0      <= b.cnt[0];
    in_arm_count_1      <= b.cnt[1];
    in_arm_count_2      <= b.cnt[2];
    in_arm_count_3      <= b.cnt[3];
    in_arm_count_4      <= b.cnt[4];
    in_arm_count_5      <= b.cnt[5];
    in_arm_count_6      <= b.cnt[6];
    in_arm_count_7      <= b.cnt[7];
    in_explore_roll     <= b.explore_roll;
    in_explore_arm_roll <= b.arm_roll;
    in_tie_roll         <= b.tie_roll;
    do @(posedge clk); while (in_stall);
    pending_picks.push_back(known ? pick : predict_pick(b, explore_pct_model));
  endtask

  // Drain the pipeline, then write the explore percentage.
  task automatic write_explore_pct(input logic [PCT_W-1:0] pct);
    in_valid <= 1'b0;
    while (pending_picks.size() != 0) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= pct;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    explore_pct_model = pct;
    settings_used++;
  endtask

  // Receiver stalls in random bursts.
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      hold = idle_len();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // Compare every output beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_picks.size() == 0) begin
        $error("output beat with no prediction: arm %0d explored %0d ties %0d",
               out_chosen_arm, out_explored, out_tie_count);
        errors++;
      end else begin
        due_pick = pending_picks.pop_front();
        picks_checked++;
        if (out_explored === 1'b1) explored_seen++;
        if (out_chosen_arm !== due_pick.arm) begin
          $error("chosen_arm: expected %0d, got %0d", due_pick.arm, out_chosen_arm);
          errors++;
        end
        if (out_explored !== due_pick.explored) begin
          $error("explored: expected %0d, got %0d", due_pick.explored, out_explored);
          errors++;
        end
        if (out_tie_count !== due_pick.ties) begin
          $error("tie_count: expected %0d, got %0d", due_pick.ties, out_tie_count);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed rows, then random phases per setting.
  initial begin
    logic [PCT_W-1:0] phase_pct [RAND_PHASES];
    phase_pct = '{7'd10, 7'd0, 7'd100, 7'd127, 7'd50, 7'd0, 7'd0, 7'd1};
    phase_pct[5] = PCT_W'($urandom_range(0, PERCENT_SPAN));
    phase_pct[6] = PCT_W'($urandom_range(0, 127));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].pct != explore_pct_model) write_explore_pct(dir_tab[r].pct);
      send_beat(dir_tab[r].beat, dir_tab[r].known, dir_tab[r].pick);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_explore_pct(phase_pct[p]);
      quiet_phase = (p == 3 || p == 6);
      for (int n = 0; n < PHASE_BEATS; n++) begin
        send_beat(random_beat(), 1'b0, no_pick);
      end
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    while (pending_picks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_picks.size() != 0) begin
      $error("%0d predicted beats never came out", pending_picks.size());
      errors++;
    end

    $display("Checked %0d output beats (%0d explored) over %0d explore settings.",
             picks_checked, explored_seen, settings_used);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d beats outstanding.", pending_picks.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
